### rtl/core/cfa_pkg.sv
// shared types and constants of the counting filter admission block
// no dependencies; imported by every module under rtl/core

package cfa_pkg;

    localparam int KEY_W         = 64;
    localparam int CNT_W         = 4;
    localparam int MASK_W        = 16;
    localparam int COUNTER_COUNT = 65536;
    localparam int IDX_W         = $clog2(COUNTER_COUNT);
    localparam int ROT_LEFT      = 33;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = MASK_W;

    localparam logic [CNT_W-1:0]  COUNTER_MAX     = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0]  THRESHOLD_RESET = CNT_W'(2);
    localparam logic [MASK_W-1:0] MASK_RESET      = {MASK_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADMIT_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_MASK      = 2'd2;

    typedef struct packed {
        logic             enable;
        logic [IDX_W-1:0] slot0;
        logic [IDX_W-1:0] slot1;
        logic [IDX_W-1:0] slot2;
    } t_probe_req;

    typedef struct packed {
        logic [CNT_W-1:0] admit_threshold;
    } t_cfg;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef struct packed {
        logic             admitted;
        logic [CNT_W-1:0] lowest_count;
    } t_result;

endpackage

### rtl/core/cfa_front.sv
// front end: configuration registers, input acceptance and probe slot calculation
// depends on cfa_pkg

module cfa_front
    import cfa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [KEY_W-1:0]      i_key_hash,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_back_status          i_back_status,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output t_probe_req            o_q_req,
    output t_cfg                  o_cfg
);

    logic              r_filter_enable;
    logic [CNT_W-1:0]  r_admit_threshold;
    logic [MASK_W-1:0] r_index_mask;

    logic [KEY_W-1:0]  second;
    logic [MASK_W-1:0] pos0;
    logic [MASK_W-1:0] pos1;
    logic [MASK_W-1:0] pos2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_enable   <= 1'b1;
            r_admit_threshold <= THRESHOLD_RESET;
            r_index_mask      <= MASK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FILTER_ENABLE:   r_filter_enable   <= i_cfg_data[0];
                CFG_ADMIT_THRESHOLD: r_admit_threshold <= i_cfg_data[CNT_W-1:0];
                CFG_INDEX_MASK:      r_index_mask      <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // only the low bits of each probe position survive the mask
    assign second = {i_key_hash[KEY_W-ROT_LEFT-1:0], i_key_hash[KEY_W-1:KEY_W-ROT_LEFT]};
    assign pos0   = i_key_hash[MASK_W-1:0];
    assign pos1   = i_key_hash[MASK_W-1:0] + second[MASK_W-1:0];
    assign pos2   = i_key_hash[MASK_W-1:0] + {second[MASK_W-2:0], 1'b0};

    assign o_full   = i_q_full | i_back_status.clearing;
    assign o_q_push = i_push & ~o_full;

    always_comb begin
        o_q_req.enable = r_filter_enable;
        o_q_req.slot0  = IDX_W'(pos0 & r_index_mask);
        o_q_req.slot1  = IDX_W'(pos1 & r_index_mask);
        o_q_req.slot2  = IDX_W'(pos2 & r_index_mask);
    end

    assign o_cfg.admit_threshold = r_admit_threshold;

endmodule

### rtl/core/cfa_req_queue.sv
// two-entry queue of probe requests between front and back
// depends on cfa_pkg

module cfa_req_queue
    import cfa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_probe_req i_req,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_valid,
    output t_probe_req o_req
);

    t_probe_req r_slots [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_req;
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_req   = r_slots[r_rd_ptr];

endmodule

### rtl/core/cfa_back.sv
// back end: counter memory with clearing pass, probe sequencer and result queue
// depends on cfa_pkg

module cfa_back
    import cfa_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_req_valid,
    input  t_probe_req   i_req,
    output logic         o_req_pop,
    input  t_cfg         i_cfg,
    output t_back_status o_status,
    output logic         o_empty,
    input  logic         i_pop,
    output logic         o_admitted,
    output logic [CNT_W-1:0] o_lowest_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_B0,
        S_B1,
        S_B2
    } t_state;

    t_state           r_state;
    logic             r_clearing;
    logic [IDX_W-1:0] r_clr_addr;
    logic [IDX_W-1:0] r_cur_addr;
    logic [IDX_W-1:0] r_slot1;
    logic [IDX_W-1:0] r_slot2;
    logic [CNT_W-1:0] r_lowest;
    logic             r_fwd_valid;
    logic [IDX_W-1:0] r_fwd_addr;
    logic [CNT_W-1:0] r_fwd_val;

    logic [CNT_W-1:0] r_mem [COUNTER_COUNT];
    logic [CNT_W-1:0] r_rd_data;

    t_result    r_res [2];
    logic       r_res_wr_ptr;
    logic       r_res_rd_ptr;
    logic [1:0] r_res_count;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [CNT_W-1:0] wr_data;
    logic [CNT_W-1:0] cur_val;
    logic [CNT_W-1:0] bumped;
    logic [CNT_W-1:0] n_lowest;
    logic             res_push;
    t_result          res_data;
    logic             res_pop;
    logic             start;

    // a read issued at the edge of the previous write sees the old value
    assign cur_val  = (r_fwd_valid && r_fwd_addr == r_cur_addr) ? r_fwd_val : r_rd_data;
    assign bumped   = (cur_val == COUNTER_MAX) ? COUNTER_MAX : cur_val + CNT_W'(1);
    assign n_lowest = (bumped < r_lowest) ? bumped : r_lowest;

    assign start     = (r_state == S_IDLE) && !r_clearing && i_req_valid && (r_res_count != 2'd2);
    assign o_req_pop = start;
    assign res_pop   = i_pop & ~o_empty;

    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = i_req.slot0;
        wr_en    = 1'b0;
        wr_addr  = r_cur_addr;
        wr_data  = bumped;
        res_push = 1'b0;
        res_data = '{admitted: 1'b1, lowest_count: COUNTER_MAX};
        case (r_state)
            S_IDLE: begin
                if (r_clearing) begin
                    wr_en   = 1'b1;
                    wr_addr = r_clr_addr;
                    wr_data = '0;
                end else if (start) begin
                    rd_en    = i_req.enable;
                    res_push = ~i_req.enable;
                end
            end
            S_B0: begin
                wr_en   = 1'b1;
                rd_en   = 1'b1;
                rd_addr = r_slot1;
            end
            S_B1: begin
                wr_en   = 1'b1;
                rd_en   = 1'b1;
                rd_addr = r_slot2;
            end
            S_B2: begin
                wr_en    = 1'b1;
                res_push = 1'b1;
                res_data = '{admitted: (n_lowest >= i_cfg.admit_threshold),
                             lowest_count: n_lowest};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (r_clearing) begin
                        r_clr_addr <= r_clr_addr + IDX_W'(1);
                        if (r_clr_addr == {IDX_W{1'b1}}) begin
                            r_clearing <= 1'b0;
                        end
                    end else if (start && i_req.enable) begin
                        r_state     <= S_B0;
                        r_cur_addr  <= i_req.slot0;
                        r_slot1     <= i_req.slot1;
                        r_slot2     <= i_req.slot2;
                        r_lowest    <= COUNTER_MAX;
                        r_fwd_valid <= 1'b0;
                    end
                end
                S_B0, S_B1: begin
                    r_state     <= (r_state == S_B0) ? S_B1 : S_B2;
                    r_cur_addr  <= rd_addr;
                    r_lowest    <= n_lowest;
                    r_fwd_valid <= 1'b1;
                    r_fwd_addr  <= r_cur_addr;
                    r_fwd_val   <= bumped;
                end
                S_B2: begin
                    r_state     <= S_IDLE;
                    r_fwd_valid <= 1'b0;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wr_ptr <= 1'b0;
            r_res_rd_ptr <= 1'b0;
            r_res_count  <= 2'd0;
        end else begin
            if (res_push) begin
                r_res_wr_ptr <= ~r_res_wr_ptr;
            end
            if (res_pop) begin
                r_res_rd_ptr <= ~r_res_rd_ptr;
            end
            r_res_count <= r_res_count + 2'(res_push) - 2'(res_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res[r_res_wr_ptr] <= res_data;
        end
    end

    assign o_empty           = (r_res_count == 2'd0);
    assign o_admitted        = r_res[r_res_rd_ptr].admitted;
    assign o_lowest_count    = r_res[r_res_rd_ptr].lowest_count;
    assign o_status.clearing = r_clearing;

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (r_state == S_IDLE && !o_req_pop))
        else $error("probe sequence started during clearing pass");

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> (r_res_count != 2'd2))
        else $error("result pushed into full result queue");

    a_seq_b0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_B0) |=> (r_state == S_B1))
        else $error("probe sequence broken after first probe");

    a_seq_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_B2) |=> (r_state == S_IDLE && $past(res_push)))
        else $error("probe sequence ended without a result");

endmodule

### rtl/core/counting_filter_admission.sv
// counting filter admission: three saturating 4-bit counter probes per key, min vs threshold
// a request is issued from the request queue; enabled, it takes an issue step plus three
// read-modify-write probes through the counter memory's one read port before the next
// starts; filter disabled, one request per cycle while the result queue has room
// reset: registers return to defaults, then a clearing pass zeroes all 65536 counters
// while full stays high; configuration writes are taken throughout

module counting_filter_admission
    import cfa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [KEY_W-1:0]      i_key_hash,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_admitted,
    output logic [CNT_W-1:0]      o_lowest_count,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_back_status back_status;
    t_probe_req   q_in_req;
    t_probe_req   q_out_req;
    t_cfg         cfg;
    logic         q_push;
    logic         q_full;
    logic         q_valid;
    logic         q_pop;

    cfa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_key_hash    (i_key_hash),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_back_status (back_status),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_req       (q_in_req),
        .o_cfg         (cfg)
    );

    cfa_req_queue u_req_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_req   (q_in_req),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_req   (q_out_req)
    );

    cfa_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (q_valid),
        .i_req          (q_out_req),
        .o_req_pop      (q_pop),
        .i_cfg          (cfg),
        .o_status       (back_status),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_admitted     (o_admitted),
        .o_lowest_count (o_lowest_count)
    );

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for counting_filter_admission: directed and random key requests
// are checked against an in-bench counter-filter predictor; depends on rtl/core/cfa_pkg.sv

module tb_top
    import cfa_pkg::*;
();

    localparam int PROBES          = 3;
    localparam int RANDOM_PHASES   = 9;
    localparam int KEYS_PER_PHASE  = 72;
    localparam int LONG_HOLD       = 300;
    localparam int DRAIN_CYCLES    = 10;
    // must outlast the counter clearing pass after reset
    localparam int STALL_LIMIT     = 4 * COUNTER_COUNT;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    class admission_board;
        logic [CNT_W-1:0]  counts [COUNTER_COUNT];
        logic              enable;
        logic [CNT_W-1:0]  threshold;
        logic [MASK_W-1:0] mask;
        t_result           expected_verdicts [$];
        int unsigned       errors;
        int unsigned       keys_noted;
        int unsigned       verdicts_checked;
        int unsigned       admits_seen;

        function void clear();
            foreach (counts[i]) counts[i] = '0;
            enable    = 1'b1;
            threshold = THRESHOLD_RESET;
            mask      = MASK_RESET;
            expected_verdicts.delete();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FILTER_ENABLE:   enable    = data[0];
                CFG_ADMIT_THRESHOLD: threshold = data[CNT_W-1:0];
                CFG_INDEX_MASK:      mask      = data[MASK_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        // three probes in order, each bumping a saturating counter
        function void note_key(logic [KEY_W-1:0] key);
            logic [KEY_W-1:0] second;
            logic [KEY_W-1:0] position;
            logic [IDX_W-1:0] slot;
            logic [CNT_W-1:0] lowest;
            t_result          verdict;
            keys_noted++;
            if (!enable) begin
                verdict.admitted     = 1'b1;
                verdict.lowest_count = COUNTER_MAX;
            end else begin
                second = {key[KEY_W-ROT_LEFT-1:0], key[KEY_W-1:KEY_W-ROT_LEFT]};
                lowest = COUNTER_MAX;
                for (int probe = 0; probe < PROBES; probe++) begin
                    position = key + KEY_W'(probe) * second;
                    slot = IDX_W'((position & KEY_W'(mask)) % COUNTER_COUNT);
                    if (counts[slot] != COUNTER_MAX) counts[slot] = counts[slot] + 1'b1;
                    if (counts[slot] < lowest) lowest = counts[slot];
                end
                verdict.admitted     = (lowest >= threshold);
                verdict.lowest_count = lowest;
            end
            expected_verdicts.push_back(verdict);
        endfunction

        function void check_result(logic admitted, logic [CNT_W-1:0] lowest_count);
            t_result want;
            if (expected_verdicts.size() == 0) begin
                errors++;
                $display("%0t: verdict with none outstanding: admitted=%0d lowest_count=%0d",
                         $time, admitted, lowest_count);
                return;
            end
            want = expected_verdicts.pop_front();
            verdicts_checked++;
            if (admitted) admits_seen++;
            if (admitted !== want.admitted) begin
                errors++;
                $display("%0t: admitted mismatch: expected %0d, actual %0d",
                         $time, want.admitted, admitted);
            end
            if (lowest_count !== want.lowest_count) begin
                errors++;
                $display("%0t: lowest_count mismatch: expected %0d, actual %0d",
                         $time, want.lowest_count, lowest_count);
            end
        endfunction
    endclass

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  push           = 1'b0;
    logic                  full;
    logic [KEY_W-1:0]      i_key_hash     = '0;
    logic                  empty;
    logic                  pop            = 1'b0;
    logic                  o_admitted;
    logic [CNT_W-1:0]      o_lowest_count;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    admission_board   board;
    int               tx_idle_pct;
    int               rx_idle_pct;
    int               rx_hold_len;
    int unsigned      stall_cycles;
    int unsigned      settings_run;
    logic [KEY_W-1:0] recent_keys [$];

    counting_filter_admission dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_key_hash     (i_key_hash),
        .empty          (empty),
        .pop            (pop),
        .o_admitted     (o_admitted),
        .o_lowest_count (o_lowest_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // request and verdict monitor plus stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) board.note_key(i_key_hash);
            if (pop && !empty) board.check_result(o_admitted, o_lowest_count);
            if ((push && !full) || (pop && !empty)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no request or verdict moved for %0d cycles", $time, STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // verdict side: random pop with one long hold-off in the random phases
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_len > 0) begin
                pop <= 1'b0;
                repeat (rx_hold_len) @(posedge i_clk);
                rx_hold_len = 0;
            end
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        board.write_reg(idx, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_key(input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_key_hash <= key;
        do @(posedge i_clk); while (full);
    endtask

    // drop push and wait for every outstanding verdict
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // repeats of recent keys are what drive counters up to the threshold
    function automatic logic [KEY_W-1:0] next_key();
        logic [KEY_W-1:0] key;
        if (recent_keys.size() != 0 && $urandom_range(99) < 40) begin
            key = recent_keys[$urandom_range(recent_keys.size() - 1)];
        end else begin
            key = {$urandom, $urandom};
            recent_keys.push_back(key);
            if (recent_keys.size() > 12) void'(recent_keys.pop_front());
        end
        return key;
    endfunction

    function automatic logic [MASK_W-1:0] pick_mask();
        case ($urandom_range(9))
            0:       return '0;
            1:       return MASK_W'(1);
            2, 3:    return '1;
            4, 5, 6: return MASK_W'((32'd1 << $urandom_range(1, MASK_W - 1)) - 1);
            default: return MASK_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    initial begin
        int p;
        int n;
        board = new();
        board.clear();
        tx_idle_pct  = 15;
        rx_idle_pct  = 70;
        rx_hold_len  = 0;
        stall_cycles = 0;
        settings_run = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values written back explicitly
        write_reg(CFG_FILTER_ENABLE, CFG_DATA_W'(1));
        write_reg(CFG_ADMIT_THRESHOLD, CFG_DATA_W'(THRESHOLD_RESET));
        write_reg(CFG_INDEX_MASK, MASK_RESET);
        // the all-zero key lands all three probes on one counter, saturating it quickly
        repeat (6) send_key('0);
        send_key('1);
        send_key(64'h8000_0000_0000_0000);
        send_key(64'h1);
        send_key({32{2'b10}});
        send_key({32{2'b01}});
        settle();

        // spare register index must be ignored; then filter off
        write_reg(CFG_SPARE, '1);
        write_reg(CFG_FILTER_ENABLE, '0);
        send_key('0);
        send_key({$urandom, $urandom});
        settle();

        // threshold zero with every probe folded onto counter zero
        write_reg(CFG_FILTER_ENABLE, CFG_DATA_W'(1));
        write_reg(CFG_ADMIT_THRESHOLD, '0);
        write_reg(CFG_INDEX_MASK, '0);
        repeat (3) send_key({$urandom, $urandom});
        settle();

        // highest threshold, mask with a hole pattern, then a one-bit mask
        write_reg(CFG_ADMIT_THRESHOLD, CFG_DATA_W'(COUNTER_MAX));
        write_reg(CFG_INDEX_MASK, 16'h00F0);
        repeat (3) send_key({$urandom, $urandom});
        settle();
        write_reg(CFG_INDEX_MASK, CFG_DATA_W'(1));
        repeat (5) send_key({$urandom, $urandom});
        settle();
        settings_run = 5;

        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p / 3)
                0:       begin tx_idle_pct = 15; rx_idle_pct = 70; end
                1:       begin tx_idle_pct = 70; rx_idle_pct = 15; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            write_reg(CFG_FILTER_ENABLE, CFG_DATA_W'($urandom_range(99) < 85));
            write_reg(CFG_ADMIT_THRESHOLD, CFG_DATA_W'($urandom_range(15)));
            write_reg(CFG_INDEX_MASK, pick_mask());
            settings_run++;
            // verdict side stalls while requests keep coming, so the block backs up
            if (p == 6) rx_hold_len = LONG_HOLD;
            for (n = 0; n < KEYS_PER_PHASE; n++) begin
                if (p == 4 && n == KEYS_PER_PHASE / 2) settle();
                send_key(next_key());
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d key requests over %0d register settings, %0d verdicts checked",
                 board.keys_noted, settings_run, board.verdicts_checked);
        $display("%0d admitted; filter off, zero/full threshold, odd masks and stalls exercised",
                 board.admits_seen);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d verdicts never arrived", board.errors, board.pending());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
